// ===== hdl/wma_pkg.sv =====
package wma_pkg;

  // Field widths.
  localparam int DATA_W = 16;
  localparam int IDX_W  = 10;
  localparam int OUT_W  = 48;

  // Parameter accumulator width, legal from 32 to 64.
  localparam int ACC_WIDTH = 48;
  localparam int EXT_W     = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

  // Category run sums.
  localparam int CAT1_W = 48;
  localparam int CAT2_W = 64;

  // Shared multiplier: 64 bit magnitude times 17 bit magnitude.
  localparam int OPA_W  = 64;
  localparam int OPB_W  = DATA_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int AP_W   = 32;
  localparam int AAP_W  = 48;
  localparam int DIGIT_W = 16;

  // Wide product register for the rounding step.
  localparam int WIDE_W = 112;

  // Rounding shifts back to 16 fraction bits.
  localparam int SH_MEAN   = 16;
  localparam int SH_SECOND = 24;
  localparam int SH_SQUARE = 40;

  typedef enum logic [2:0] {
    MUL_AP  = 3'd0,
    MUL_AAP = 3'd1,
    MUL_S1W = 3'd2,
    MUL_S2W = 3'd3,
    MUL_D2  = 3'd4,
    MUL_D1  = 3'd5,
    MUL_D0  = 3'd6
  } mul_sel_t;

  typedef enum logic [1:0] {
    W_HOLD  = 2'd0,
    W_LOAD  = 2'd1,
    W_CLEAR = 2'd2,
    W_MAC   = 2'd3
  } w_op_t;

  typedef enum logic [1:0] {
    SC_MEAN   = 2'd0,
    SC_SECOND = 2'd1,
    SC_SQUARE = 2'd2
  } scale_sel_t;

  typedef enum logic [1:0] {
    ADD_NONE   = 2'd0,
    ADD_MEAN   = 2'd1,
    ADD_SECOND = 2'd2,
    ADD_SQUARE = 2'd3
  } add_sel_t;

  typedef struct packed {
    logic       latch_in;
    mul_sel_t   mul_sel;
    logic       cat1_add;
    logic       cat2_add;
    logic       cat_clear;
    logic       latch_mag;
    logic       t_load;
    w_op_t      w_op;
    logic       scale_en;
    scale_sel_t scale_sel;
    add_sel_t   add_sel;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic last_cat;
    logic last_par;
    logic out_busy;
  } status_t;

endpackage

// ===== hdl/weighted_moment_accumulator.sv =====
// Weighted moment accumulator. Items arrive one at a time on the input channel,
// and the next item is accepted only once the last one is through. An item that
// closes a category run or a parameter also goes through the run sum steps, and
// one that closes a parameter then waits for the output register to free up.
// Their pace is set by the single 64x17 bit multiplier that every
// product goes through in turn: score*prob, score*score*prob, the run sum times
// the weight, and the squared term in three 16 bit digit steps. A finished result
// sits in an output register, so the next item is accepted while it waits to be
// taken. All sums saturate; the saturated flag reports any clip since the last
// result.
module weighted_moment_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [wma_pkg::DATA_W-1:0] score,
  input  logic        [wma_pkg::DATA_W-1:0] prob,
  input  logic        [wma_pkg::DATA_W-1:0] weight,
  input  logic        [wma_pkg::IDX_W-1:0]  param_index,
  input  logic                              last_category,
  input  logic                              last_of_param,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [wma_pkg::IDX_W-1:0]  out_index,
  output logic signed [wma_pkg::OUT_W-1:0]  mean_sum,
  output logic signed [wma_pkg::OUT_W-1:0]  square_sum,
  output logic signed [wma_pkg::OUT_W-1:0]  second_sum,
  output logic                              saturated
);
  import wma_pkg::*;

  cmd_t    cmd;
  status_t status;

  wma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wma_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .score         (score),
    .prob          (prob),
    .weight        (weight),
    .param_index   (param_index),
    .last_category (last_category),
    .last_of_param (last_of_param),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_index     (out_index),
    .mean_sum      (mean_sum),
    .square_sum    (square_sum),
    .second_sum    (second_sum),
    .saturated     (saturated)
  );

endmodule

// ===== hdl/wma_ctrl.sv =====
module wma_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wma_pkg::status_t status,
  output wma_pkg::cmd_t    cmd
);
  import wma_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_AP     = 16'b0000_0000_0000_0010,
    S_AAP    = 16'b0000_0000_0000_0100,
    S_CAT2   = 16'b0000_0000_0000_1000,
    S_FMUL   = 16'b0000_0000_0001_0000,
    S_MLOAD  = 16'b0000_0000_0010_0000,
    S_MSCALE = 16'b0000_0000_0100_0000,
    S_MADD   = 16'b0000_0000_1000_0000,
    S_SSCALE = 16'b0000_0001_0000_0000,
    S_SADD   = 16'b0000_0010_0000_0000,
    S_Q2     = 16'b0000_0100_0000_0000,
    S_Q1     = 16'b0000_1000_0000_0000,
    S_Q0     = 16'b0001_0000_0000_0000,
    S_QSCALE = 16'b0010_0000_0000_0000,
    S_QADD   = 16'b0100_0000_0000_0000,
    S_EMIT   = 16'b1000_0000_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_next = S_AP;
        end
      end
      S_AP: begin
        cmd.mul_sel = MUL_AP;
        state_next  = S_AAP;
      end
      S_AAP: begin
        cmd.cat1_add = 1'b1;
        cmd.mul_sel  = MUL_AAP;
        state_next   = S_CAT2;
      end
      S_CAT2: begin
        cmd.cat2_add = 1'b1;
        if (status.last_cat || status.last_par) begin
          state_next = S_FMUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FMUL: begin
        // Magnitudes are captured here, so the run sums can clear at once.
        cmd.mul_sel   = MUL_S1W;
        cmd.latch_mag = 1'b1;
        cmd.cat_clear = 1'b1;
        state_next    = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.w_op    = W_LOAD;
        cmd.t_load  = 1'b1;
        cmd.mul_sel = MUL_S2W;
        state_next  = S_MSCALE;
      end
      S_MSCALE: begin
        cmd.scale_en  = 1'b1;
        cmd.scale_sel = SC_MEAN;
        cmd.w_op      = W_LOAD;
        state_next    = S_MADD;
      end
      S_MADD: begin
        cmd.add_sel = ADD_MEAN;
        state_next  = S_SSCALE;
      end
      S_SSCALE: begin
        cmd.scale_en  = 1'b1;
        cmd.scale_sel = SC_SECOND;
        state_next    = S_SADD;
      end
      S_SADD: begin
        cmd.add_sel = ADD_SECOND;
        cmd.w_op    = W_CLEAR;
        cmd.mul_sel = MUL_D2;
        state_next  = S_Q2;
      end
      S_Q2: begin
        cmd.w_op    = W_MAC;
        cmd.mul_sel = MUL_D1;
        state_next  = S_Q1;
      end
      S_Q1: begin
        cmd.w_op    = W_MAC;
        cmd.mul_sel = MUL_D0;
        state_next  = S_Q0;
      end
      S_Q0: begin
        cmd.w_op   = W_MAC;
        state_next = S_QSCALE;
      end
      S_QSCALE: begin
        cmd.scale_en  = 1'b1;
        cmd.scale_sel = SC_SQUARE;
        state_next    = S_QADD;
      end
      S_QADD: begin
        cmd.add_sel = ADD_SQUARE;
        if (status.last_par) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        // Hold here while the previous result still sits in the output register.
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("a second item was taken while one is in work");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy)
    else $error("result written over an untaken result");

  a_emit_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.last_par)
    else $error("result emitted for an item that does not close a parameter");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    cmd.cat1_add |=> cmd.cat2_add)
    else $error("second moment update did not follow first moment update");
`endif

endmodule

// ===== hdl/wma_datapath.sv =====
module wma_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wma_pkg::cmd_t                          cmd,
  output wma_pkg::status_t                       status,
  input  logic signed [wma_pkg::DATA_W-1:0]      score,
  input  logic        [wma_pkg::DATA_W-1:0]      prob,
  input  logic        [wma_pkg::DATA_W-1:0]      weight,
  input  logic        [wma_pkg::IDX_W-1:0]       param_index,
  input  logic                                   last_category,
  input  logic                                   last_of_param,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [wma_pkg::IDX_W-1:0]       out_index,
  output logic signed [wma_pkg::OUT_W-1:0]       mean_sum,
  output logic signed [wma_pkg::OUT_W-1:0]       square_sum,
  output logic signed [wma_pkg::OUT_W-1:0]       second_sum,
  output logic                                   saturated
);
  import wma_pkg::*;

  // Returns {clipped, value} with the accumulator clamped to the output range.
  function automatic logic [OUT_W:0] clamp_out(input logic [ACC_WIDTH-1:0] v);
    logic [EXT_W-1:0]       x;
    logic [EXT_W-OUT_W:0]   hi;
    x  = EXT_W'($signed(v));
    hi = x[EXT_W-1:OUT_W-1];
    if ((&hi) || !(|hi)) begin
      clamp_out = {1'b0, x[OUT_W-1:0]};
    end else begin
      clamp_out = {1'b1, x[EXT_W-1], {(OUT_W-1){~x[EXT_W-1]}}};
    end
  endfunction

  // Latched input item.
  logic [DATA_W:0]         a_mag;
  logic                    a_neg;
  logic [DATA_W-1:0]       prob_q;
  logic [DATA_W-1:0]       weight_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    last_cat_q;
  logic                    last_par_q;
  logic signed [DATA_W:0]  score_x;

  // Multiplier.
  logic [OPA_W-1:0]        opa;
  logic [OPB_W-1:0]        opb;
  logic [PROD_W-1:0]       mul_c;
  logic [PROD_W-1:0]       prod;

  // Run sums and their folded magnitudes.
  logic signed [CAT1_W-1:0] cat1;
  logic signed [CAT2_W-1:0] cat2;
  logic [CAT1_W-1:0]        cat1_mag;
  logic [CAT2_W-1:0]        cat2_mag;
  logic [CAT1_W-1:0]        s1_mag;
  logic                     s1_neg;
  logic [CAT2_W-1:0]        s2_mag;
  logic                     s2_neg;
  logic [OPA_W-1:0]         t_mag;
  logic signed [AP_W:0]     ap_s;
  logic [CAT1_W:0]          sum1;
  logic [CAT2_W:0]          sum2;
  logic                     ovf1;
  logic                     ovf2;
  logic [CAT1_W-1:0]        cat1_next;
  logic [CAT2_W-1:0]        cat2_next;

  // Rounding and accumulation.
  logic [WIDE_W-1:0]        wide;
  logic [WIDE_W-1:0]        q;
  logic [WIDE_W-1:0]        lim;
  logic [WIDE_W-1:0]        qs;
  logic                     tneg;
  logic                     sclip;
  logic [ACC_WIDTH-1:0]     term_c;
  logic signed [ACC_WIDTH-1:0] term;
  logic signed [ACC_WIDTH-1:0] acc_mean;
  logic signed [ACC_WIDTH-1:0] acc_square;
  logic signed [ACC_WIDTH-1:0] acc_second;
  logic [ACC_WIDTH-1:0]     acc_cur;
  logic [ACC_WIDTH:0]       sum_a;
  logic                     ovf_a;
  logic [ACC_WIDTH-1:0]     acc_next;
  logic                     clip;
  logic                     clip_next;
  logic [OUT_W:0]           cm_mean;
  logic [OUT_W:0]           cm_square;
  logic [OUT_W:0]           cm_second;

  assign score_x = {score[DATA_W-1], score};

  assign status.last_cat = last_cat_q;
  assign status.last_par = last_par_q;
  assign status.out_busy = out_valid && !out_ready;

  assign cat1_mag = cat1[CAT1_W-1] ? CAT1_W'(-cat1) : CAT1_W'(cat1);
  assign cat2_mag = cat2[CAT2_W-1] ? CAT2_W'(-cat2) : CAT2_W'(cat2);

  // Operand selection for the shared multiplier; all operands are magnitudes.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_AP: begin
        opa = OPA_W'(prob_q);
        opb = a_mag;
      end
      MUL_AAP: begin
        opa = OPA_W'(prod[AP_W-1:0]);
        opb = a_mag;
      end
      MUL_S1W: begin
        opa = OPA_W'(cat1_mag);
        opb = OPB_W'(weight_q);
      end
      MUL_S2W: begin
        opa = s2_mag;
        opb = OPB_W'(weight_q);
      end
      MUL_D2: begin
        opa = t_mag;
        opb = OPB_W'(s1_mag[2*DIGIT_W +: DIGIT_W]);
      end
      MUL_D1: begin
        opa = t_mag;
        opb = OPB_W'(s1_mag[DIGIT_W +: DIGIT_W]);
      end
      MUL_D0: begin
        opa = t_mag;
        opb = OPB_W'(s1_mag[0 +: DIGIT_W]);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul_c = PROD_W'(opa) * PROD_W'(opb);

  // Saturating run sums. The squared term a*a*p is never negative.
  always_comb begin
    ap_s = a_neg ? -$signed({1'b0, prod[AP_W-1:0]}) : $signed({1'b0, prod[AP_W-1:0]});
    sum1 = {cat1[CAT1_W-1], cat1} + (CAT1_W+1)'(ap_s);
    ovf1 = sum1[CAT1_W] ^ sum1[CAT1_W-1];
    if (ovf1) begin
      cat1_next = {sum1[CAT1_W], {(CAT1_W-1){~sum1[CAT1_W]}}};
    end else begin
      cat1_next = sum1[CAT1_W-1:0];
    end
    sum2 = {cat2[CAT2_W-1], cat2} + (CAT2_W+1)'(prod[AAP_W-1:0]);
    ovf2 = sum2[CAT2_W] ^ sum2[CAT2_W-1];
    if (ovf2) begin
      cat2_next = {sum2[CAT2_W], {(CAT2_W-1){~sum2[CAT2_W]}}};
    end else begin
      cat2_next = sum2[CAT2_W-1:0];
    end
  end

  // Round half away from zero on the magnitude, then clip to the accumulator range.
  always_comb begin
    unique case (cmd.scale_sel)
      SC_MEAN: begin
        q    = (wide + (WIDE_W'(1) << (SH_MEAN - 1))) >> SH_MEAN;
        tneg = s1_neg;
      end
      SC_SECOND: begin
        q    = (wide + (WIDE_W'(1) << (SH_SECOND - 1))) >> SH_SECOND;
        tneg = s2_neg;
      end
      SC_SQUARE: begin
        q    = (wide + (WIDE_W'(1) << (SH_SQUARE - 1))) >> SH_SQUARE;
        tneg = 1'b0;
      end
      default: begin
        q    = '0;
        tneg = 1'b0;
      end
    endcase
    if (tneg) begin
      lim = WIDE_W'(1) << (ACC_WIDTH - 1);
    end else begin
      lim = (WIDE_W'(1) << (ACC_WIDTH - 1)) - WIDE_W'(1);
    end
    sclip  = (q > lim);
    qs     = sclip ? lim : q;
    term_c = tneg ? ACC_WIDTH'(WIDE_W'(0) - qs) : qs[ACC_WIDTH-1:0];
  end

  always_comb begin
    unique case (cmd.add_sel)
      ADD_NONE:   acc_cur = acc_mean;
      ADD_MEAN:   acc_cur = acc_mean;
      ADD_SECOND: acc_cur = acc_second;
      ADD_SQUARE: acc_cur = acc_square;
    endcase
    sum_a = {acc_cur[ACC_WIDTH-1], acc_cur} + {term[ACC_WIDTH-1], term};
    ovf_a = sum_a[ACC_WIDTH] ^ sum_a[ACC_WIDTH-1];
    if (ovf_a) begin
      acc_next = {sum_a[ACC_WIDTH], {(ACC_WIDTH-1){~sum_a[ACC_WIDTH]}}};
    end else begin
      acc_next = sum_a[ACC_WIDTH-1:0];
    end
  end

  assign cm_mean   = clamp_out(acc_mean);
  assign cm_square = clamp_out(acc_square);
  assign cm_second = clamp_out(acc_second);

  always_comb begin
    clip_next = clip;
    if (cmd.emit) begin
      clip_next = 1'b0;
    end else begin
      if (cmd.cat1_add && ovf1) begin
        clip_next = 1'b1;
      end
      if (cmd.cat2_add && ovf2) begin
        clip_next = 1'b1;
      end
      if (cmd.scale_en && sclip) begin
        clip_next = 1'b1;
      end
      if ((cmd.add_sel != ADD_NONE) && ovf_a) begin
        clip_next = 1'b1;
      end
    end
  end

  // Control state and sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      cat1       <= '0;
      cat2       <= '0;
      acc_mean   <= '0;
      acc_square <= '0;
      acc_second <= '0;
      clip       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.cat_clear) begin
        cat1 <= '0;
        cat2 <= '0;
      end else begin
        if (cmd.cat1_add) begin
          cat1 <= cat1_next;
        end
        if (cmd.cat2_add) begin
          cat2 <= cat2_next;
        end
      end
      if (cmd.emit) begin
        acc_mean   <= '0;
        acc_square <= '0;
        acc_second <= '0;
      end else begin
        unique case (cmd.add_sel)
          ADD_NONE:   ;
          ADD_MEAN:   acc_mean   <= acc_next;
          ADD_SECOND: acc_second <= acc_next;
          ADD_SQUARE: acc_square <= acc_next;
        endcase
      end
      clip <= clip_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_mag      <= score_x[DATA_W] ? (DATA_W+1)'(-score_x) : (DATA_W+1)'(score_x);
      a_neg      <= score_x[DATA_W];
      prob_q     <= prob;
      weight_q   <= weight;
      idx_q      <= param_index;
      last_cat_q <= last_category;
      last_par_q <= last_of_param;
    end
    prod <= mul_c;
    if (cmd.latch_mag) begin
      s1_mag <= cat1_mag;
      s1_neg <= cat1[CAT1_W-1];
      s2_mag <= cat2_mag;
      s2_neg <= cat2[CAT2_W-1];
    end
    if (cmd.t_load) begin
      t_mag <= prod[OPA_W-1:0];
    end
    unique case (cmd.w_op)
      W_HOLD:  ;
      W_LOAD:  wide <= WIDE_W'(prod);
      W_CLEAR: wide <= '0;
      W_MAC:   wide <= (wide << DIGIT_W) + WIDE_W'(prod);
    endcase
    if (cmd.scale_en) begin
      term <= term_c;
    end
    if (cmd.emit) begin
      out_index  <= idx_q;
      mean_sum   <= cm_mean[OUT_W-1:0];
      square_sum <= cm_square[OUT_W-1:0];
      second_sum <= cm_second[OUT_W-1:0];
      saturated  <= clip | cm_mean[OUT_W] | cm_square[OUT_W] | cm_second[OUT_W];
    end
  end

endmodule
